// ----- rtl/core/mab_pkg.sv -----
// mab_pkg: shared types and constants for the mirrored ARGB8888-over-RGB565 blender.
// No dependencies; imported by every module under rtl/core.
package mab_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BYTES    = 3'd4;

  localparam int COORD_W = 10;
  localparam int ADDR_W  = 17;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  ALPHA_MAX = 8'd255;
  localparam logic [16:0] ROUND_ADD = 17'd127;

  typedef struct packed {
    logic               drop;
    logic               swap;
    logic [COORD_W-1:0] fx;
    logic [COORD_W-1:0] fy;
    logic [31:0]        src;
    logic [15:0]        dst;
  } qitem_t;

endpackage

// ----- rtl/core/mab_front.sv -----
// mab_front: configuration registers and item classification (mirror, clip, alpha 0).
// Depends on mab_pkg.
module mab_front import mab_pkg::*; #(
  parameter int FRAME_W = 320,
  parameter int FRAME_H = 240
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [8:0]            src_col,
  input  logic [7:0]            src_row,
  input  logic [31:0]           src_pixel,
  input  logic [15:0]           dest_pixel,
  output qitem_t                item
);

  logic [9:0] dest_x_r;
  logic [8:0] dest_y_r;
  logic [8:0] sprite_width_r;
  logic [7:0] sprite_height_r;
  logic       swap_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_x_r        <= '0;
      dest_y_r        <= '0;
      sprite_width_r  <= 9'd1;
      sprite_height_r <= 8'd1;
      swap_bytes_r    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEST_X:        dest_x_r        <= cfg_data;
        CFG_DEST_Y:        dest_y_r        <= cfg_data[8:0];
        CFG_SPRITE_WIDTH:  sprite_width_r  <= cfg_data[8:0];
        CFG_SPRITE_HEIGHT: sprite_height_r <= cfg_data[7:0];
        CFG_SWAP_BYTES:    swap_bytes_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic signed [11:0] fx;
  logic signed [11:0] fy;
  logic               outside;
  logic               reject;

  always_comb begin
    fx = {{2{dest_x_r[9]}}, dest_x_r} + {3'b0, sprite_width_r} - 12'd1 - {3'b0, src_col};
    fy = {{3{dest_y_r[8]}}, dest_y_r} + {4'b0, src_row};
    outside = (fx < 0) || (fx >= $signed(12'(FRAME_W)))
           || (fy < 0) || (fy >= $signed(12'(FRAME_H)));
    reject  = (src_pixel[31:24] == 8'd0) || (src_col >= sprite_width_r)
           || (src_row >= sprite_height_r);
    item.drop = reject || outside;
    item.swap = swap_bytes_r;
    item.fx   = fx[COORD_W-1:0];
    item.fy   = fy[COORD_W-1:0];
    item.src  = src_pixel;
    item.dst  = swap_bytes_r ? {dest_pixel[7:0], dest_pixel[15:8]} : dest_pixel;
  end

endmodule

// ----- rtl/core/mab_queue.sv -----
// mab_queue: short FIFO of classified beats between front and back.
// Depends on mab_pkg.
module mab_queue import mab_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qitem_t push_item,
  input  logic   pop,
  output qitem_t pop_item,
  output logic   empty,
  output logic   full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  qitem_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_item = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ----- rtl/core/mab_back.sv -----
// mab_back: three-stage blend and address pipeline feeding the result register.
// Depends on mab_pkg.
module mab_back import mab_pkg::*; #(
  parameter int FRAME_W = 320
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  qitem_t            item,
  output logic              out_valid,
  output logic              out_write_enable,
  output logic [ADDR_W-1:0] out_dest_addr,
  output logic [15:0]       out_pixel_out
);

  localparam int PROD_W = COORD_W + $clog2(FRAME_W + 1) + 1;
  localparam int ROW_W  = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

  // stage 1: products and row offset
  logic               s1_valid_r;
  logic               s1_drop_r;
  logic               s1_swap_r;
  logic [COORD_W-1:0] s1_fx_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [2:0][15:0]   s1_ps_r;
  logic [2:0][15:0]   s1_pd_r;

  logic [7:0]       alpha;
  logic [7:0]       ialpha;
  logic [2:0][7:0]  s_ch;
  logic [2:0][7:0]  d_ch;

  always_comb begin
    alpha  = item.src[31:24];
    ialpha = ALPHA_MAX - alpha;
    s_ch[2] = item.src[23:16];
    s_ch[1] = item.src[15:8];
    s_ch[0] = item.src[7:0];
    d_ch[2] = {item.dst[15:11], 3'b0};
    d_ch[1] = {item.dst[10:5], 2'b0};
    d_ch[0] = {item.dst[4:0], 3'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    s1_drop_r <= item.drop;
    s1_swap_r <= item.swap;
    s1_fx_r   <= item.fx;
    s1_row_r  <= ROW_W'(item.fy) * ROW_W'(FRAME_W);
    for (int i = 0; i < 3; i++) begin
      s1_ps_r[i] <= 16'(s_ch[i]) * 16'(alpha);
      s1_pd_r[i] <= 16'(d_ch[i]) * 16'(ialpha);
    end
  end

  // stage 2: rounding divide by 255 and address add
  logic              s2_valid_r;
  logic              s2_drop_r;
  logic              s2_swap_r;
  logic [ADDR_W-1:0] s2_addr_r;
  logic [2:0][7:0]   s2_ch_r;

  logic [2:0][16:0] sum;
  logic [2:0][16:0] quo;
  logic [ROW_W-1:0] addr_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = 17'(s1_ps_r[i]) + 17'(s1_pd_r[i]) + ROUND_ADD;
      quo[i] = (sum[i] + (sum[i] >> 8) + 17'd1) >> 8;
    end
    addr_full = s1_row_r + ROW_W'(s1_fx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else        s2_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    s2_drop_r <= s1_drop_r;
    s2_swap_r <= s1_swap_r;
    s2_addr_r <= addr_full[ADDR_W-1:0];
    for (int i = 0; i < 3; i++) begin
      s2_ch_r[i] <= quo[i][7:0];
    end
  end

  // stage 3: pack, swap, result register
  logic [15:0] packed_pix;
  logic [15:0] final_pix;

  always_comb begin
    packed_pix = {s2_ch_r[2][7:3], s2_ch_r[1][7:2], s2_ch_r[0][7:3]};
    final_pix  = s2_swap_r ? {packed_pix[7:0], packed_pix[15:8]} : packed_pix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid        <= 1'b0;
      out_write_enable <= 1'b0;
      out_dest_addr    <= '0;
      out_pixel_out    <= '0;
    end else begin
      out_valid        <= s2_valid_r;
      out_write_enable <= s2_valid_r && !s2_drop_r;
      out_dest_addr    <= (s2_valid_r && !s2_drop_r) ? s2_addr_r : '0;
      out_pixel_out    <= (s2_valid_r && !s2_drop_r) ? final_pix : '0;
    end
  end

`ifndef SYNTH
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> s2_valid_r) else $error("stage 2 lost a beat");
  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |=> out_valid) else $error("result register lost a beat");
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_dest_addr == '0 && out_pixel_out == '0)
    else $error("dropped beat carries data");
  a_we_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_write_enable) else $error("write enable without strobe");
`endif

endmodule

// ----- rtl/core/mirrored_alpha_blend_rgb565.sv -----
// mirrored_alpha_blend_rgb565: top level of the mirrored sprite blender.
// Depends on mab_pkg, mab_front, mab_queue, mab_back.
//
// Usage:
//   Input: a beat is taken at a clock edge with start high and busy low. It carries
//   the sprite pixel's stored column and row, its ARGB8888 color and the frame pixel
//   currently at the mirrored target.
//   Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
//   Index 0 dest_x, 1 dest_y, 2 sprite_width, 3 sprite_height, 4 swap_bytes; other
//   indexes are ignored. Write only while no beat is in flight.
//   Output: every input beat yields one result, shown for a single cycle with
//   out_valid high. Dropped pixels come out with out_write_enable, out_dest_addr and
//   out_pixel_out all zero.
//   Path: the accepting edge writes the queue, then the product stage, the divide
//   stage and the result register take the beat in that order.
//   Throughput: one beat per cycle; the back pipeline never stalls, so the two-entry
//   queue never fills and busy stays low in operation.
//   Reset (rst_n low, synchronous): pipeline emptied, registers return to dest 0,0,
//   size 1x1, no byte swap. The receiver cannot stall the result channel.
module mirrored_alpha_blend_rgb565 import mab_pkg::*; #(
  parameter int FRAME_W = 320,
  parameter int FRAME_H = 240
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [8:0]            in_src_col,
  input  logic [7:0]            in_src_row,
  input  logic [31:0]           in_src_pixel,
  input  logic [15:0]           in_dest_pixel,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic                  out_write_enable,
  output logic [ADDR_W-1:0]     out_dest_addr,
  output logic [15:0]           out_pixel_out
);

  qitem_t front_item;
  qitem_t back_item;
  logic   q_empty;
  logic   q_full;
  logic   accept;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign accept    = start && !q_full;

  mab_front #(
    .FRAME_W (FRAME_W),
    .FRAME_H (FRAME_H)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .src_col    (in_src_col),
    .src_row    (in_src_row),
    .src_pixel  (in_src_pixel),
    .dest_pixel (in_dest_pixel),
    .item       (front_item)
  );

  mab_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (front_item),
    .pop       (!q_empty),
    .pop_item  (back_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  mab_back #(
    .FRAME_W (FRAME_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (!q_empty),
    .item             (back_item),
    .out_valid        (out_valid),
    .out_write_enable (out_write_enable),
    .out_dest_addr    (out_dest_addr),
    .out_pixel_out    (out_pixel_out)
  );

endmodule
